// ----- hdl/mts_pkg.sv -----
// mts_pkg: shared types for the min threshold strong connectivity block
// controller states and the command and status groups between the two modules
// no dependencies
`timescale 1ns / 1ps

package mts_pkg;

    // controller states, one-hot
    typedef enum logic [9:0] {
        S_LOAD      = 10'b0000000001,
        S_RECALC    = 10'b0000000010,
        S_START     = 10'b0000000100,
        S_CHECK     = 10'b0000001000,
        S_OUTER     = 10'b0000010000,
        S_SCAN_RD   = 10'b0000100000,
        S_SCAN_TEST = 10'b0001000000,
        S_REV_START = 10'b0010000000,
        S_DECIDE    = 10'b0100000000,
        S_EMIT      = 10'b1000000000
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic cfg_write;
        logic div_start;
        logic div_step;
        logic search_init;
        logic fwd_init;
        logic outer_skip;
        logic outer_push;
        logic scan_rd;
        logic scan_push;
        logic scan_next;
        logic scan_pop;
        logic rev_init;
        logic decide;
        logic emit;
    } cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic div_last;
        logic range_open;
        logic outer_done;
        logic outer_visited;
        logic scan_hit;
        logic scan_last;
        logic depth_one;
        logic reverse;
        logic out_busy;
    } status_t;

endpackage

// ----- hdl/mts_datapath.sv -----
// mts_datapath: weight memory, load counters, search bounds, depth-first walk stack
// and result register; driven by mts_controller commands
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_datapath #(
    parameter int MAX_VERTICES = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  mts_pkg::cmd_t   cmd,
    output mts_pkg::status_t status,
    input  logic [4:0]      vertex_count,
    input  logic [30:0]     edge_weight,
    input  logic            out_ready,
    output logic            out_valid,
    output logic [30:0]     min_threshold
);
    import mts_pkg::*;

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int CW    = $clog2(MAX_VERTICES * MAX_VERTICES + 1);
    localparam int PW    = 2 * NW;
    localparam int DW    = $clog2(CW + 1);
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;

    // weight memory, one write and one registered read port
    logic [30:0]   mem [DEPTH];
    logic [30:0]   mem_q_reg;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;

    logic [4:0]    vc_reg;
    logic [NW-1:0] n_act;
    logic [PW-1:0] n_sq;
    logic          full;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] row_reg, row_next;
    logic [VW-1:0] col_reg, col_next;
    logic [30:0]   largest_reg, largest_next;

    logic [CW-1:0] div_dq_reg, div_dq_next;
    logic [NW-1:0] div_rem_reg, div_rem_next;
    logic [DW-1:0] div_cnt_reg, div_cnt_next;
    logic [NW:0]   rem_sh;
    logic          rem_ge;
    logic [NW:0]   rem_sub;
    logic [CW:0]   dq_sh;

    logic [31:0]   low_reg, low_next;
    logic [30:0]   high_reg, high_next;
    logic [32:0]   bound_sum;
    logic [32:0]   bound_diff;
    logic [30:0]   mid;

    logic [VW-1:0] stack_reg [MAX_VERTICES];
    logic [NW-1:0] depth_reg, depth_next;
    logic [VW-1:0] top;
    logic [VW-1:0] next_reg, next_next;
    logic [NW-1:0] outer_reg, outer_next;
    logic [NW-1:0] comp_reg, comp_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [VW-1:0] last_fin_reg, last_fin_next;
    logic          rev_reg, rev_next;
    logic          push_en;
    logic [VW-1:0] push_vtx;

    logic          out_valid_reg, out_valid_next;
    logic [30:0]   out_reg;

    // active vertex count, clamped into range
    always_comb
    begin
        if (vc_reg == 5'd0)
            n_act = NW'(1);
        else if (32'(vc_reg) > MAX_VERTICES)
            n_act = NW'(MAX_VERTICES);
        else
            n_act = NW'(vc_reg);
    end

    assign n_sq = PW'(n_act) * PW'(n_act);
    assign full = PW'(cnt_reg) >= n_sq;

    // restoring division step for row and column after a count change
    assign rem_sh  = {div_rem_reg, div_dq_reg[CW-1]};
    assign rem_ge  = rem_sh >= {1'b0, n_act};
    assign rem_sub = rem_ge ? (rem_sh - {1'b0, n_act}) : rem_sh;
    assign dq_sh   = {div_dq_reg, rem_ge};

    // search bounds and midpoint
    assign bound_sum  = {low_reg[31], low_reg} + {2'b00, high_reg};
    assign bound_diff = {2'b00, high_reg} - {low_reg[31], low_reg};
    assign mid        = bound_sum[31:1];

    // walk addressing
    assign top       = stack_reg[VW'(depth_reg - NW'(1))];
    assign mem_waddr = {row_reg[VW-1:0], col_reg};
    assign mem_raddr = rev_reg ? {next_reg, top} : {top, next_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load && !full)
            mem[mem_waddr] <= edge_weight;
        if (cmd.scan_rd)
            mem_q_reg <= mem[mem_raddr];
    end

    // next-state logic for counters, bounds and walk state
    always_comb
    begin
        cnt_next      = cnt_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        largest_next  = largest_reg;
        div_dq_next   = div_dq_reg;
        div_rem_next  = div_rem_reg;
        div_cnt_next  = div_cnt_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        depth_next    = depth_reg;
        next_next     = next_reg;
        outer_next    = outer_reg;
        comp_next     = comp_reg;
        visited_next  = visited_reg;
        last_fin_next = last_fin_reg;
        rev_next      = rev_reg;
        push_en       = 1'b0;
        push_vtx      = next_reg;
        out_valid_next = out_valid_reg;

        // entry load
        if (cmd.load && !full)
        begin
            cnt_next = cnt_reg + CW'(1);
            if (edge_weight > largest_reg)
                largest_next = edge_weight;
            if (NW'(col_reg) + NW'(1) == n_act)
            begin
                col_next = '0;
                row_next = row_reg + NW'(1);
            end
            else
            begin
                col_next = col_reg + VW'(1);
            end
        end

        // row and column recomputation
        if (cmd.div_start)
        begin
            div_dq_next  = cnt_reg;
            div_rem_next = '0;
            div_cnt_next = DW'(CW);
        end
        else if (cmd.div_step)
        begin
            div_dq_next  = dq_sh[CW-1:0];
            div_rem_next = rem_sub[NW-1:0];
            div_cnt_next = div_cnt_reg - DW'(1);
            if (div_cnt_reg == DW'(1))
            begin
                row_next = dq_sh[NW-1:0];
                col_next = rem_sub[VW-1:0];
            end
        end

        if (cmd.search_init)
        begin
            low_next  = '1;
            high_next = largest_reg;
        end

        // forward pass start
        if (cmd.fwd_init)
        begin
            visited_next = '0;
            outer_next   = '0;
            comp_next    = '0;
            depth_next   = '0;
            rev_next     = 1'b0;
        end

        if (cmd.outer_skip)
            outer_next = outer_reg + NW'(1);

        if (cmd.outer_push)
        begin
            push_en    = 1'b1;
            push_vtx   = outer_reg[VW-1:0];
            outer_next = outer_reg + NW'(1);
        end

        if (cmd.scan_push)
        begin
            push_en  = 1'b1;
            push_vtx = next_reg;
        end

        if (cmd.scan_next)
            next_next = next_reg + VW'(1);

        // pop, record finish in the forward pass
        if (cmd.scan_pop)
        begin
            depth_next = depth_reg - NW'(1);
            next_next  = '0;
            if (!rev_reg)
                last_fin_next = top;
        end

        // reverse pass start from the last finished vertex
        if (cmd.rev_init)
        begin
            visited_next = '0;
            comp_next    = '0;
            depth_next   = '0;
            rev_next     = 1'b1;
            push_en      = 1'b1;
            push_vtx     = last_fin_reg;
        end

        if (push_en)
        begin
            visited_next[push_vtx] = 1'b1;
            comp_next  = comp_next + NW'(1);
            depth_next = depth_next + NW'(1);
            next_next  = '0;
        end

        // bound update
        if (cmd.decide)
        begin
            if (comp_reg == n_act)
                high_next = mid;
            else
                low_next = {1'b0, mid};
        end

        // result register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            cnt_next       = '0;
            row_next       = '0;
            col_next       = '0;
            largest_next   = '0;
            low_next       = '1;
            high_next      = '0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= 5'd16;
            cnt_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            largest_reg   <= '0;
            div_cnt_reg   <= '0;
            low_reg       <= '1;
            high_reg      <= '0;
            depth_reg     <= '0;
            next_reg      <= '0;
            outer_reg     <= '0;
            comp_reg      <= '0;
            visited_reg   <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_write)
                vc_reg <= vertex_count;
            cnt_reg       <= cnt_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            largest_reg   <= largest_next;
            div_cnt_reg   <= div_cnt_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            depth_reg     <= depth_next;
            next_reg      <= next_next;
            outer_reg     <= outer_next;
            comp_reg      <= comp_next;
            visited_reg   <= visited_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        div_dq_reg   <= div_dq_next;
        div_rem_reg  <= div_rem_next;
        last_fin_reg <= last_fin_next;
        if (push_en)
            stack_reg[VW'(depth_next - NW'(1))] <= push_vtx;
        if (cmd.emit)
            out_reg <= high_reg;
    end

    // status to the controller
    assign status.div_last      = div_cnt_reg == DW'(1);
    assign status.range_open    = !bound_diff[32] && (bound_diff[31:0] > 32'd1);
    assign status.outer_done    = outer_reg == n_act;
    assign status.outer_visited = visited_reg[outer_reg[VW-1:0]];
    assign status.scan_hit      = !visited_reg[next_reg] && (mem_q_reg <= mid);
    assign status.scan_last     = NW'(next_reg) + NW'(1) == n_act;
    assign status.depth_one     = depth_reg == NW'(1);
    assign status.reverse       = rev_reg;
    assign status.out_busy      = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign min_threshold = out_reg;

    // walk stack never holds more vertices than are in use
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= n_act)
        else $error("walk stack deeper than vertex count");

    // a result clears the load state and raises valid
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (out_valid_reg && cnt_reg == '0 && largest_reg == '0))
        else $error("load state not cleared after result");

    // the upper bound never grows during a search
    a_high_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide |=> (high_reg <= $past(high_reg)))
        else $error("upper bound increased");

endmodule

// ----- hdl/mts_controller.sv -----
// mts_controller: state machine sequencing load, binary search and the two
// depth-first passes of each connectivity test
// depends on mts_pkg
`timescale 1ns / 1ps

module mts_controller (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_entry,
    input  logic             cfg_valid,
    input  mts_pkg::status_t status,
    output logic             in_ready,
    output logic             cfg_ready,
    output mts_pkg::cmd_t    cmd
);
    import mts_pkg::*;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;

        case (state_reg)
            S_LOAD:
            begin
                cfg_ready = 1'b1;
                in_ready  = !cfg_valid;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = S_RECALC;
                end
                else if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_entry)
                        state_next = S_START;
                end
            end
            S_RECALC:
            begin
                cfg_ready = 1'b1;
                if (cfg_valid)
                begin
                    cmd.cfg_write = 1'b1;
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (status.div_last)
                        state_next = S_LOAD;
                end
            end
            S_START:
            begin
                cmd.search_init = 1'b1;
                state_next      = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.range_open)
                begin
                    cmd.fwd_init = 1'b1;
                    state_next   = S_OUTER;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_OUTER:
            begin
                if (status.outer_done)
                    state_next = S_REV_START;
                else if (status.outer_visited)
                    cmd.outer_skip = 1'b1;
                else
                begin
                    cmd.outer_push = 1'b1;
                    state_next     = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCAN_TEST;
            end
            S_SCAN_TEST:
            begin
                if (status.scan_hit)
                begin
                    cmd.scan_push = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else if (!status.scan_last)
                begin
                    cmd.scan_next = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else
                begin
                    cmd.scan_pop = 1'b1;
                    if (!status.depth_one)
                        state_next = S_SCAN_RD;
                    else if (status.reverse)
                        state_next = S_DECIDE;
                    else
                        state_next = S_OUTER;
                end
            end
            S_REV_START:
            begin
                cmd.rev_init = 1'b1;
                state_next   = S_SCAN_RD;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_CHECK;
            end
            S_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    // the marked final entry always starts a search
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_entry) |=> (state_reg == S_START))
        else $error("final entry did not start the search");

    // no input transfer while a search is running
    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_LOAD))
        else $error("entry taken outside the load state");

    // a result is only produced once the range has closed
    a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !status.range_open)
        else $error("result produced with an open search range");

endmodule

// ----- hdl/min_threshold_strong_connectivity.sv -----
// min_threshold_strong_connectivity: top level joining controller and datapath
// depends on mts_pkg, mts_controller, mts_datapath
//
// Usage: write vertex_count (n, clamped to 1..MAX_VERTICES) on the cfg channel,
// then send the n*n weight matrix in row-major order on the input channel,
// one entry per transfer, with last_entry set on the final one. Entries past
// n*n are dropped; a last_entry still starts the search.
// Entries are taken back to back while in_ready is high. A config
// transfer re-derives the load row and column with a bit-serial divider,
// during which in_ready is low.
// The search runs ceil(log2(largest+2)) rounds at most; each round is two
// depth-first passes, each weight memory read issued in a read state and
// tested in the next state, through the single weight memory read port.
// The result appears on min_threshold with out_valid and is held in an output
// register, so loading of the next matrix goes on while the receiver stalls;
// a second search waits to emit until the first result is taken.
// Reset clears the counters and bounds and sets vertex_count to 16; the
// weight memory is not cleared and keeps its contents across searches.
`timescale 1ns / 1ps

module min_threshold_strong_connectivity #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  vertex_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [30:0] edge_weight,
    input  logic        last_entry,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] min_threshold
);
    import mts_pkg::*;

    cmd_t    cmd;
    status_t status;

    mts_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .cfg_valid  (cfg_valid),
        .status     (status),
        .in_ready   (in_ready),
        .cfg_ready  (cfg_ready),
        .cmd        (cmd)
    );

    mts_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .vertex_count  (vertex_count),
        .edge_weight   (edge_weight),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .min_threshold (min_threshold)
    );

endmodule
